@@ rtl/nps_pkg.sv @@
package nps_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int COLOR_W       = 8;
   localparam int SLOT_W        = 5;
   localparam int FILTER_W      = 2;
   localparam int DIST_W        = 29;
   localparam int SQ_W          = 2 * COLOR_W;
   localparam int WEIGHT_W      = 11;
   localparam int PROD_W        = 27;
   localparam int MAX_DIST      = 332667900;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [FILTER_W-1:0] FILTER_ANY   = 2'd0;
   localparam logic [FILTER_W-1:0] FILTER_DARK  = 2'd1;
   localparam logic [FILTER_W-1:0] FILTER_LIGHT = 2'd2;

   // redmean weights, scaled by 512
   localparam logic [WEIGHT_W-1:0] RED_WEIGHT_BASE  = 11'd1024;
   localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_BASE = 11'd1534;
   localparam int GREEN_SHIFT = 11;

   typedef struct packed {
      logic               valid;
      logic               dark;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } entry_type;

   typedef struct packed {
      logic vld;
      logic last;
      logic match;
   } tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT
   } state_type;

endpackage

@@ rtl/nearest_palette_colour_search_core.sv @@
// Nearest palette color search, redmean metric.
// Input channel: an item is taken on a clock edge with start high and busy low.
//   req_mode = write: slot req_slot gets color, dark flag and valid bit;
//     a slot at or beyond DEPTH is left untouched. The response follows in the
//     next cycle: found 0, best_index = slot, best_distance 0. busy stays low, so a
//     new transaction may be started on the very next edge.
//   req_mode = query: the palette ring rotates once through a 4-stage
//     distance pipeline, one entry per cycle, and the running best is kept
//     (lowest index wins on ties). The response strobe comes once the last entry
//     leaves the pipeline; busy stays high from the accepting edge until that
//     strobe, so queries do not overlap: the single shared distance pipeline
//     walks the ring one entry per cycle.
// Result channel: rsp_valid is high for one cycle with found, best_index and
//   best_distance; the receiver must take it then, there is no back-pressure.
// Reset: every palette slot is cleared and invalid, no transaction in flight.
module nearest_palette_colour_search_core
   import nps_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   input  logic                req_dark_flag,
   input  logic                req_entry_valid,
   input  logic [FILTER_W-1:0] req_bg_filter,
   output logic                rsp_valid,
   output logic                rsp_found,
   output logic [SLOT_W-1:0]   rsp_best_index,
   output logic [DIST_W-1:0]   rsp_best_distance
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [IW-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [COLOR_W-1:0]  q_red_ff, q_green_ff, q_blue_ff;
   logic [FILTER_W-1:0] q_filter_ff;

   logic              have_ff, have_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [IW-1:0]     cmp_idx_ff, cmp_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0] rsp_best_index_ff, rsp_best_index_in;
   logic [DIST_W-1:0] rsp_best_distance_ff, rsp_best_distance_in;

   logic accept, wr_go, query_go, shift, head_match;

   entry_type wr_data;
   entry_type cell_q [DEPTH];
   logic [DEPTH-1:0] wr_en;

   tag_type           tag_in, tag_out;
   logic [DIST_W-1:0] entry_dist;

   assign accept   = start && !busy;
   assign wr_go    = accept && (req_mode == MODE_WRITE);
   assign query_go = accept && (req_mode == MODE_QUERY);

   assign wr_data = '{valid: req_entry_valid, dark: req_dark_flag,
                      red: req_red, green: req_green, blue: req_blue};

   // palette ring: cell i takes from cell i+1, cell 0 feeds the distance unit
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i < (1 << SLOT_W)) begin : g_addr
         assign wr_en[i] = wr_go && (req_slot == SLOT_W'(i));
      end else begin : g_noaddr
         assign wr_en[i] = 1'b0;
      end

      nps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .wr_en      (wr_en[i]),
         .wr_data    (wr_data),
         .next_entry (cell_q[(i + 1) % DEPTH]),
         .entry      (cell_q[i])
      );
   end

   always_comb begin
      priority if (q_filter_ff == FILTER_DARK) begin
         head_match = cell_q[0].valid && cell_q[0].dark;
      end else if (q_filter_ff == FILTER_LIGHT) begin
         head_match = cell_q[0].valid && !cell_q[0].dark;
      end else begin
         head_match = cell_q[0].valid;
      end
   end

   nps_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .tag_in     (tag_in),
      .entry      (cell_q[0]),
      .q_red      (q_red_ff),
      .q_green    (q_green_ff),
      .q_blue     (q_blue_ff),
      .tag_out    (tag_out),
      .entry_dist (entry_dist)
   );

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      shift       = 1'b0;
      tag_in      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in    = ST_SCAN;
               scan_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            shift        = 1'b1;
            tag_in.vld   = 1'b1;
            tag_in.match = head_match;
            tag_in.last  = (scan_cnt_ff == LAST_IDX);
            scan_cnt_in  = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == LAST_IDX) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (tag_out.vld && tag_out.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // running best over the pipeline output
   always_comb begin
      have_in     = have_ff;
      best_idx_in = best_idx_ff;
      best_d_in   = best_d_ff;
      cmp_idx_in  = cmp_idx_ff;
      if (query_go) begin
         have_in     = 1'b0;
         best_idx_in = '0;
         best_d_in   = '0;
         cmp_idx_in  = '0;
      end else if (tag_out.vld) begin
         cmp_idx_in = cmp_idx_ff + 1'b1;
         if (tag_out.match && (!have_ff || (entry_dist < best_d_ff))) begin
            have_in     = 1'b1;
            best_idx_in = cmp_idx_ff;
            best_d_in   = entry_dist;
         end
      end
   end

   always_comb begin
      rsp_valid_in         = 1'b0;
      rsp_found_in         = rsp_found_ff;
      rsp_best_index_in    = rsp_best_index_ff;
      rsp_best_distance_in = rsp_best_distance_ff;
      if (wr_go) begin
         rsp_valid_in         = 1'b1;
         rsp_found_in         = 1'b0;
         rsp_best_index_in    = req_slot;
         rsp_best_distance_in = '0;
      end else if (tag_out.vld && tag_out.last) begin
         rsp_valid_in         = 1'b1;
         rsp_found_in         = have_in;
         rsp_best_index_in    = SLOT_W'(best_idx_in);
         rsp_best_distance_in = best_d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         have_ff      <= 1'b0;
         cmp_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         have_ff      <= have_in;
         cmp_idx_ff   <= cmp_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff          <= best_idx_in;
      best_d_ff            <= best_d_in;
      rsp_found_ff         <= rsp_found_in;
      rsp_best_index_ff    <= rsp_best_index_in;
      rsp_best_distance_ff <= rsp_best_distance_in;
      if (query_go) begin
         q_red_ff    <= req_red;
         q_green_ff  <= req_green;
         q_blue_ff   <= req_blue;
         q_filter_ff <= req_bg_filter;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_best_index    = rsp_best_index_ff;
   assign rsp_best_distance = rsp_best_distance_ff;

   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("response strobe during ring scan");

   a_last_in_wait: assert property (@(posedge clock) disable iff (reset)
      (tag_out.vld && tag_out.last) |-> (state_ff == ST_WAIT))
      else $error("last distance arrived outside wait state");

   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_go |=> (rsp_valid_ff && !rsp_found_ff && (rsp_best_distance_ff == '0)))
      else $error("write transaction response malformed");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_best_distance_ff <= DIST_W'(MAX_DIST)))
      else $error("distance out of range");

endmodule

@@ rtl/nps_cell.sv @@
module nps_cell
   import nps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  logic      wr_en,
   input  entry_type wr_data,
   input  entry_type next_entry,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // a write lands in the home position; during a scan the ring rotates
   always_comb begin
      entry_in = entry_ff;
      if (wr_en) begin
         entry_in = wr_data;
      end else if (shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

@@ rtl/nps_dist.sv @@
module nps_dist
   import nps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tag_type            tag_in,
   input  entry_type          entry,
   input  logic [COLOR_W-1:0] q_red,
   input  logic [COLOR_W-1:0] q_green,
   input  logic [COLOR_W-1:0] q_blue,
   output tag_type            tag_out,
   output logic [DIST_W-1:0]  entry_dist
);

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   logic [COLOR_W-1:0]  dr_in, dg_in, db_in, dr_ff, dg_ff, db_ff;
   logic [COLOR_W:0]    rsum_in, rsum_ff;
   logic [SQ_W-1:0]     sqr_in, sqg_in, sqb_in, sqr_ff, sqg_ff, sqb_ff;
   logic [WEIGHT_W-1:0] wr_in, wb_in, wr_ff, wb_ff;
   logic [PROD_W-1:0]   pr_in, pg_in, pb_in, pr_ff, pg_ff, pb_ff;
   logic [DIST_W-1:0]   dist_in, dist_ff;

   // stage 1: differences and red sum
   always_comb begin
      dr_in   = (q_red   >= entry.red)   ? q_red   - entry.red   : entry.red   - q_red;
      dg_in   = (q_green >= entry.green) ? q_green - entry.green : entry.green - q_green;
      db_in   = (q_blue  >= entry.blue)  ? q_blue  - entry.blue  : entry.blue  - q_blue;
      rsum_in = {1'b0, q_red} + {1'b0, entry.red};
   end

   // stage 2: squares and weights
   always_comb begin
      sqr_in = {{COLOR_W{1'b0}}, dr_ff} * {{COLOR_W{1'b0}}, dr_ff};
      sqg_in = {{COLOR_W{1'b0}}, dg_ff} * {{COLOR_W{1'b0}}, dg_ff};
      sqb_in = {{COLOR_W{1'b0}}, db_ff} * {{COLOR_W{1'b0}}, db_ff};
      wr_in  = RED_WEIGHT_BASE  + {2'b00, rsum_ff};
      wb_in  = BLUE_WEIGHT_BASE - {2'b00, rsum_ff};
   end

   // stage 3: weighted terms
   always_comb begin
      pr_in = {{(PROD_W-WEIGHT_W){1'b0}}, wr_ff} * {{(PROD_W-SQ_W){1'b0}}, sqr_ff};
      pg_in = {sqg_ff, {GREEN_SHIFT{1'b0}}};
      pb_in = {{(PROD_W-WEIGHT_W){1'b0}}, wb_ff} * {{(PROD_W-SQ_W){1'b0}}, sqb_ff};
   end

   // stage 4: sum
   always_comb begin
      dist_in = {2'b00, pr_ff} + {2'b00, pg_ff} + {2'b00, pb_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      dr_ff   <= dr_in;
      dg_ff   <= dg_in;
      db_ff   <= db_in;
      rsum_ff <= rsum_in;
      sqr_ff  <= sqr_in;
      sqg_ff  <= sqg_in;
      sqb_ff  <= sqb_in;
      wr_ff   <= wr_in;
      wb_ff   <= wb_in;
      pr_ff   <= pr_in;
      pg_ff   <= pg_in;
      pb_ff   <= pb_in;
      dist_ff <= dist_in;
   end

   assign tag_out    = tag4_ff;
   assign entry_dist = dist_ff;

   a_tag_latency: assert property (@(posedge clock) disable iff (reset)
      tag4_ff.vld |-> $past(tag_in.vld, 4))
      else $error("distance pipeline produced an entry that never entered");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import nps_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1830;
   localparam logic [FILTER_W-1:0] FILTER_SPARE = 2'd3;   // decodes as "any"

   typedef struct {
      logic              found;
      logic [SLOT_W-1:0] index;
      logic [DIST_W-1:0] distance;
   } search_result_type;

   // Tracks palette contents and the queue of responses still owed by the core.
   class palette_search_scoreboard;
      entry_type         palette [DEPTH];
      search_result_type owed [$];
      int unsigned       mismatches;

      function new();
         foreach (palette[i]) palette[i] = '0;
         mismatches = 0;
      endfunction

      function automatic logic [31:0] redmean_distance(logic [COLOR_W-1:0] r,
                                                       logic [COLOR_W-1:0] g,
                                                       logic [COLOR_W-1:0] b,
                                                       entry_type e);
         logic [31:0] rsum, dr, dg, db;
         rsum = 32'(r) + 32'(e.red);
         dr = (r >= e.red) ? 32'(r - e.red) : 32'(e.red - r);
         dg = (g >= e.green) ? 32'(g - e.green) : 32'(e.green - g);
         db = (b >= e.blue) ? 32'(b - e.blue) : 32'(e.blue - b);
         return (32'(RED_WEIGHT_BASE) + rsum) * dr * dr
              + (32'd1 << GREEN_SHIFT) * dg * dg
              + (32'(BLUE_WEIGHT_BASE) - rsum) * db * db;
      endfunction

      function automatic void note_transaction(logic mode, logic [SLOT_W-1:0] slot,
                                               logic [COLOR_W-1:0] r,
                                               logic [COLOR_W-1:0] g,
                                               logic [COLOR_W-1:0] b,
                                               logic dark, logic valid,
                                               logic [FILTER_W-1:0] filter);
         search_result_type res;
         logic [31:0] d;
         res.found = 1'b0;
         res.index = '0;
         res.distance = '0;
         if (mode == MODE_WRITE) begin
            if (int'(slot) < DEPTH) begin
               palette[slot].valid = valid;
               palette[slot].dark  = dark;
               palette[slot].red   = r;
               palette[slot].green = g;
               palette[slot].blue  = b;
            end
            res.index = slot;
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!palette[i].valid) continue;
               if (filter == FILTER_DARK && !palette[i].dark) continue;
               if (filter == FILTER_LIGHT && palette[i].dark) continue;
               d = redmean_distance(r, g, b, palette[i]);
               // strict compare keeps the lower index on ties
               if (!res.found || d < 32'(res.distance)) begin
                  res.found = 1'b1;
                  res.index = SLOT_W'(i);
                  res.distance = DIST_W'(d);
               end
            end
         end
         owed.insert(owed.size(), res);
      endfunction

      function automatic void check_response(logic found, logic [SLOT_W-1:0] index,
                                             logic [DIST_W-1:0] distance);
         search_result_type exp;
         if (owed.size() == 0) begin
            $error("unexpected response: found %0d index %0d distance %0d",
                   found, index, distance);
            mismatches++;
            return;
         end
         exp = owed.pop_front();
         if (found !== exp.found) begin
            $error("found mismatch: expected %0d, actual %0d", exp.found, found);
            mismatches++;
         end
         if (index !== exp.index) begin
            $error("best_index mismatch: expected %0d, actual %0d", exp.index, index);
            mismatches++;
         end
         if (distance !== exp.distance) begin
            $error("best_distance mismatch: expected %0d, actual %0d",
                   exp.distance, distance);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_mode = MODE_WRITE;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [COLOR_W-1:0]  req_red = '0;
   logic [COLOR_W-1:0]  req_green = '0;
   logic [COLOR_W-1:0]  req_blue = '0;
   logic                req_dark_flag = 1'b0;
   logic                req_entry_valid = 1'b0;
   logic [FILTER_W-1:0] req_bg_filter = FILTER_ANY;
   logic                rsp_valid;
   logic                rsp_found;
   logic [SLOT_W-1:0]   rsp_best_index;
   logic [DIST_W-1:0]   rsp_best_distance;

   palette_search_scoreboard sb = new();
   int unsigned cycles = 0;
   bit no_idle = 1'b0;
   int unsigned valid_pct = 80;

   nearest_palette_colour_search_core #(.DEPTH(DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_slot(req_slot),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .req_dark_flag(req_dark_flag),
      .req_entry_valid(req_entry_valid),
      .req_bg_filter(req_bg_filter),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_best_index(rsp_best_index),
      .rsp_best_distance(rsp_best_distance)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response checked before noting a new transaction on the same edge:
   // the response always belongs to an earlier one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_response(rsp_found, rsp_best_index, rsp_best_distance);
         if (start && !busy)
            sb.note_transaction(req_mode, req_slot, req_red, req_green, req_blue,
                                req_dark_flag, req_entry_valid, req_bg_filter);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(4, 45);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return COLOR_W'($urandom_range(0, 3) * 85);   // coarse grid makes ties
         default: return COLOR_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Leaves start high when gap is 0 so the next transaction follows directly.
   task automatic send_item(logic mode, logic [SLOT_W-1:0] slot,
                            logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                            logic [COLOR_W-1:0] b, logic dark, logic valid,
                            logic [FILTER_W-1:0] filter, int unsigned gap);
      req_mode        <= mode;
      req_slot        <= slot;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_dark_flag   <= dark;
      req_entry_valid <= valid;
      req_bg_filter   <= filter;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic mode;
      logic valid;
      mode = ($urandom_range(0, 99) < 45) ? MODE_WRITE : MODE_QUERY;
      valid = ($urandom_range(0, 99) < valid_pct);
      send_item(mode, SLOT_W'($urandom_range(0, DEPTH - 1)), pick_level(), pick_level(),
                pick_level(), 1'($urandom_range(0, 1)), valid,
                FILTER_W'($urandom_range(0, 3)), pick_gap());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty palette
      send_item(MODE_QUERY, 5'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, FILTER_ANY, pick_gap());
      send_item(MODE_QUERY, 5'd31, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, FILTER_DARK, 0);
      // extremes; write carries junk query fields
      send_item(MODE_WRITE, 5'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, FILTER_SPARE, 0);
      send_item(MODE_WRITE, 5'd31, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, FILTER_DARK, pick_gap());
      send_item(MODE_QUERY, 5'd17, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, FILTER_ANY, 0);
      send_item(MODE_QUERY, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, FILTER_DARK, 0);
      send_item(MODE_QUERY, 5'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, FILTER_LIGHT, pick_gap());
      send_item(MODE_QUERY, 5'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, FILTER_SPARE, 0);
      send_item(MODE_QUERY, 5'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b0, FILTER_DARK, 0);
      send_item(MODE_QUERY, 5'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, FILTER_LIGHT, pick_gap());
      send_item(MODE_QUERY, 5'd0, 8'd128, 8'd127, 8'd128, 1'b0, 1'b0, FILTER_ANY, 0);
      // duplicate color: tie resolves to the lower slot
      send_item(MODE_WRITE, 5'd5, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, FILTER_ANY, 0);
      send_item(MODE_QUERY, 5'd0, 8'd250, 8'd250, 8'd250, 1'b0, 1'b0, FILTER_ANY, 0);
      send_item(MODE_QUERY, 5'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, FILTER_DARK, 0);
      // remove entries
      send_item(MODE_WRITE, 5'd0, 8'd1, 8'd2, 8'd3, 1'b1, 1'b0, FILTER_ANY, pick_gap());
      send_item(MODE_QUERY, 5'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, FILTER_LIGHT, 0);
      send_item(MODE_QUERY, 5'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, FILTER_ANY, 0);
      send_item(MODE_WRITE, 5'd31, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, FILTER_ANY, 0);
      send_item(MODE_WRITE, 5'd5, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, FILTER_ANY, 0);
      send_item(MODE_QUERY, 5'd0, 8'd10, 8'd20, 8'd30, 1'b0, 1'b0, FILTER_DARK, pick_gap());
      // back-to-back writes then a query right behind them
      send_item(MODE_WRITE, 5'd12, 8'd85, 8'd170, 8'd255, 1'b1, 1'b1, FILTER_ANY, 0);
      send_item(MODE_WRITE, 5'd13, 8'd85, 8'd170, 8'd255, 1'b0, 1'b1, FILTER_ANY, 0);
      send_item(MODE_QUERY, 5'd0, 8'd85, 8'd170, 8'd255, 1'b0, 1'b0, FILTER_LIGHT, 0);
      send_item(MODE_QUERY, 5'd0, 8'd85, 8'd170, 8'd255, 1'b0, 1'b0, FILTER_SPARE, 0);

      // random phases vary palette occupancy and idle behavior
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 3))
               0: valid_pct = 95;
               1: valid_pct = 70;
               2: valid_pct = 40;
               default: valid_pct = 5;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
         end
         send_random();
      end
      start <= 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
